@@ design/position_command_ramp_smoother_assert.svh @@
// Assertion macros for the position command ramp smoother.
// Included by the top level; needs clk and rst_n in scope.
`ifndef POSITION_COMMAND_RAMP_SMOOTHER_ASSERT_SVH
`define POSITION_COMMAND_RAMP_SMOOTHER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcrs assertion failed");

// Next-cycle implication, disabled during reset.
`define PCRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcrs assertion failed");

`endif

@@ design/pcrs_pkg.sv @@
// Shared widths and register indexes for the position command ramp smoother.
// No dependencies.
package pcrs_pkg;

    localparam int CMD_W  = 32;
    localparam int RAMP_W = 16;
    localparam int REM_W  = RAMP_W + 1;
    localparam int CNT_W  = $clog2(CMD_W);
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_SMOOTH_ENABLE = 1'b0;
    localparam logic [IDX_W-1:0] REG_RAMP_STEPS    = 1'b1;

    typedef logic [CMD_W-1:0] cmd_t;

endpackage

@@ design/position_command_ramp_smoother.sv @@
// Position command ramp smoother: one smoothed command for each servo tick.
// Depends on pcrs_pkg and position_command_ramp_smoother_assert.svh.
//
// A tick that holds, steps along a ramp, or passes through (smoothing off)
// has its result in the output register the cycle after transfer in. A tick
// whose command differs from the previous one starts a ramp: the gap is
// divided by ramp_steps in a restoring divider that shares one 17-bit
// subtract and compare over 32 iterations, then a finish state applies the
// step. The input stalls while a division runs and while a finished result
// waits in the output register. Write configuration only while idle.
module position_command_ramp_smoother
    import pcrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_index,
    input  logic [RAMP_W-1:0] wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  cmd_t              position_command,
    output logic              out_valid,
    input  logic              out_stall,
    output cmd_t              smoothed_command
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     en_reg;
    logic [RAMP_W-1:0]        ramp_reg;
    cmd_t                     cur_reg, cur_next;
    cmd_t                     prev_reg, prev_next;
    logic signed [CMD_W-1:0]  step_reg, step_next;
    logic signed [REM_W-1:0]  left_reg, left_next;
    cmd_t                     cmd_reg, cmd_next;
    logic                     neg_reg, neg_next;
    logic [RAMP_W-1:0]        div_reg, div_next;
    cmd_t                     quo_reg, quo_next;
    logic [RAMP_W-1:0]        rem_reg, rem_next;
    logic                     out_valid_reg, out_valid_next;
    cmd_t                     out_reg, out_next;

    logic                     in_xfer;
    logic                     out_free;
    cmd_t                     gap;
    logic [REM_W-1:0]         trial;
    logic                     fits;
    cmd_t                     corr_run;
    cmd_t                     stepped;
    logic signed [CMD_W-1:0]  q_signed;
    logic signed [REM_W-1:0]  r_signed;
    cmd_t                     corr_fin;
    cmd_t                     fin_out;

    assign out_free         = !out_valid_reg || !out_stall;
    assign in_stall         = (state_reg != ST_IDLE) || !out_free;
    assign in_xfer          = in_valid && !in_stall;
    assign out_valid        = out_valid_reg;
    assign smoothed_command = out_reg;

    assign gap = position_command - cur_reg;

    // Shared divider iteration: shift in one dividend bit, trial subtract.
    assign trial = {rem_reg, quo_reg[CMD_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    // Ramp tick: step plus the pending +/-1 correction.
    assign corr_run = (left_reg > 0) ? cmd_t'(1) :
                      (left_reg < 0) ? '1 : '0;
    assign stepped  = cur_reg + cmd_t'(step_reg) + corr_run;

    // Division result with signs restored, truncated toward zero.
    assign q_signed = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign r_signed = neg_reg ? -$signed({1'b0, rem_reg}) : $signed({1'b0, rem_reg});
    assign corr_fin = (r_signed > 0) ? cmd_t'(1) :
                      (r_signed < 0) ? '1 : '0;
    assign fin_out  = cur_reg + cmd_t'(q_signed) + corr_fin;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        step_next      = step_reg;
        left_next      = left_reg;
        cmd_next       = cmd_reg;
        neg_next       = neg_reg;
        div_next       = div_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!en_reg)
                    begin
                        cur_next       = position_command;
                        prev_next      = position_command;
                        out_next       = position_command;
                        out_valid_next = 1'b1;
                    end
                    else if (position_command != prev_reg)
                    begin
                        // New target: start the division of the gap.
                        cmd_next   = position_command;
                        neg_next   = gap[CMD_W-1];
                        quo_next   = gap[CMD_W-1] ? (~gap + cmd_t'(1)) : gap;
                        rem_next   = '0;
                        div_next   = (ramp_reg == '0) ? RAMP_W'(1) : ramp_reg;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        if (cur_reg != position_command)
                        begin
                            cur_next = stepped;
                            if (left_reg > 0)
                                left_next = left_reg - REM_W'(1);
                            else if (left_reg < 0)
                                left_next = left_reg + REM_W'(1);
                            // Clamp where the step would pass the command.
                            if (step_reg > 0)
                            begin
                                if ($signed(position_command) < $signed(stepped))
                                    cur_next = position_command;
                            end
                            else
                            begin
                                if ($signed(position_command) > $signed(stepped))
                                    cur_next = position_command;
                            end
                        end
                        prev_next      = position_command;
                        out_next       = cur_next;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = fits ? RAMP_W'(trial - {1'b0, div_reg}) : trial[RAMP_W-1:0];
                quo_next = {quo_reg[CMD_W-2:0], fits};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CMD_W - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold until the output register is free.
                if (out_free)
                begin
                    step_next = q_signed;
                    if (r_signed > 0)
                        left_next = r_signed - REM_W'(1);
                    else if (r_signed < 0)
                        left_next = r_signed + REM_W'(1);
                    else
                        left_next = r_signed;
                    cur_next       = fin_out;
                    prev_next      = cmd_reg;
                    out_next       = fin_out;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            en_reg        <= 1'b0;
            ramp_reg      <= RAMP_W'(1);
            cur_reg       <= '0;
            prev_reg      <= '0;
            step_reg      <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            step_reg      <= step_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_SMOOTH_ENABLE: en_reg   <= wr_data[0];
                    REG_RAMP_STEPS:    ramp_reg <= wr_data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        neg_reg <= neg_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        out_reg <= out_next;
    end

`include "position_command_ramp_smoother_assert.svh"

    `PCRS_ASSERT_IMP(a_div_stalls, state_reg != ST_IDLE, in_stall)
    `PCRS_ASSERT_NEXT(a_xfer_makes_work, in_xfer, out_valid_reg || state_reg == ST_DIV)
    `PCRS_ASSERT_NEXT(a_div_ends, state_reg == ST_DIV && cnt_reg == CNT_W'(CMD_W - 1),
        state_reg == ST_FIN)
    `PCRS_ASSERT_IMP(a_rem_below_div, state_reg == ST_FIN, rem_reg < div_reg)

endmodule
